FILE: sv/frr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frr_pkg
// Shared types, codes and field widths for the fragment frame reassembler.
// ----------------------------------------------------------------------------
package frr_pkg;

  localparam int FRAG_BYTES_DEF = 1400;
  localparam int MAX_FRAGS_DEF  = 64;
  localparam int SLOTS_DEF      = 8;

  localparam int FRAME_ID_W    = 32;
  localparam int FRAG_IDX_W    = 6;
  localparam int FRAG_CNT_W    = 7;
  localparam int FRAME_BYTES_W = 17;
  localparam int OFFSET_W      = 11;
  localparam int SLOT_FIELD_W  = 3;
  localparam int ADDR_FIELD_W  = 17;

  localparam logic [FRAG_CNT_W-1:0] SEEN_MAX = '1;

  typedef enum logic [2:0] {
    ST_STORED  = 3'd0,
    ST_DONE    = 3'd1,
    ST_NO_SLOT = 3'd2,
    ST_RANGE   = 3'd3,
    ST_READ    = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_LOOKUP,
    S_UPDATE
  } state_t;

  typedef struct packed {
    logic                     mode;
    logic [FRAME_ID_W-1:0]    frame_number;
    logic [FRAG_IDX_W-1:0]    frag_index;
    logic [FRAG_CNT_W-1:0]    frag_count;
    logic [FRAME_BYTES_W-1:0] frame_bytes;
    logic [OFFSET_W-1:0]      byte_offset;
    logic [7:0]               payload_byte;
    logic                     end_of_fragment;
    logic [SLOT_FIELD_W-1:0]  read_slot;
    logic [ADDR_FIELD_W-1:0]  read_address;
  } item_t;

  typedef struct packed {
    status_t                  status;
    logic [FRAME_ID_W-1:0]    done_frame_number;
    logic [SLOT_FIELD_W-1:0]  done_slot;
    logic [FRAME_BYTES_W-1:0] done_frame_bytes;
    logic [7:0]               read_data;
  } result_t;

  // per-slot fragment count and frame size held in the slot table memory
  typedef struct packed {
    logic [FRAG_CNT_W-1:0]    seen;
    logic [FRAME_BYTES_W-1:0] size;
  } meta_t;

  typedef struct packed {
    logic hit;
    logic avail;
  } lookup_t;

  typedef struct packed {
    logic open;
    logic close;
    logic meta_we;
  } slot_upd_t;

endpackage

FILE: sv/frr_slot_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frr_slot_table
// Slot ownership flags and frame ids with parallel match, plus a small
// synchronous memory of per-slot fragment counts and frame sizes.
// ----------------------------------------------------------------------------
module frr_slot_table #(
  parameter int SLOTS  = frr_pkg::SLOTS_DEF,
  parameter int SLOT_W = 3
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic [frr_pkg::FRAME_ID_W-1:0]   lookup_id,
  input  logic                             lookup_en,
  output frr_pkg::lookup_t                 lookup,
  output logic [SLOT_W-1:0]                lookup_slot,
  input  frr_pkg::slot_upd_t               upd,
  input  logic [SLOT_W-1:0]                upd_slot,
  input  logic [frr_pkg::FRAME_ID_W-1:0]   upd_id,
  input  frr_pkg::meta_t                   upd_meta,
  output frr_pkg::meta_t                   rd_meta
);

  logic [SLOTS-1:0]               slot_open;
  logic [frr_pkg::FRAME_ID_W-1:0] slot_id [SLOTS];
  frr_pkg::meta_t                 meta_mem [SLOTS];

  logic [SLOTS-1:0]  hit_vec;
  logic [SLOT_W-1:0] hit_slot;
  logic [SLOT_W-1:0] free_slot;

  always_comb begin
    for (int s = 0; s < SLOTS; s++) begin
      hit_vec[s] = slot_open[s] && (slot_id[s] == lookup_id);
    end
  end

  // lowest matching slot first, else lowest free one
  always_comb begin
    hit_slot  = '0;
    free_slot = '0;
    for (int s = SLOTS - 1; s >= 0; s--) begin
      if (hit_vec[s]) hit_slot = SLOT_W'(s);
      if (!slot_open[s]) free_slot = SLOT_W'(s);
    end
  end

  always_comb begin
    lookup.hit   = |hit_vec;
    lookup.avail = (|hit_vec) || !(&slot_open);
    lookup_slot  = (|hit_vec) ? hit_slot : free_slot;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_open <= '0;
    end else begin
      if (upd.open) slot_open[upd_slot] <= 1'b1;
      if (upd.close) slot_open[upd_slot] <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (upd.open) slot_id[upd_slot] <= upd_id;
  end

  always_ff @(posedge clk) begin
    if (upd.meta_we) meta_mem[upd_slot] <= upd_meta;
    if (lookup_en) rd_meta <= meta_mem[lookup_slot];
  end

endmodule

FILE: sv/frr_frame_store.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frr_frame_store
// Single-port byte RAM holding the reassembled frames, registered read.
// ----------------------------------------------------------------------------
module frr_frame_store #(
  parameter int DEPTH  = 716800,
  parameter int ADDR_W = 20
) (
  input  logic              clk,
  input  logic              we,
  input  logic              re,
  input  logic [ADDR_W-1:0] addr,
  input  logic [7:0]        wdata,
  output logic [7:0]        rdata
);

  logic [7:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[addr] <= wdata;
    if (re) rdata <= mem[addr];
  end

endmodule

FILE: sv/fragment_frame_reassembler.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fragment_frame_reassembler
// Rebuilds frames from byte-wide fragment words into per-slot frame buffers.
// ----------------------------------------------------------------------------
//  channel   ports                         handshake
//  command   start, busy, item             taken when start && !busy
//  result    result_valid, result          one cycle per word, no stall
//
// Every word passes through lookup (header checks, slot match, counter
// and store reads), update (counter write-back, store write) and idle,
// in which the result is shown. This sequence is set by the read-modify-
// write of the slot counter memory and the single frame store port.
// Synchronous reset clears slot ownership, state and the result strobe;
// the frame store needs no clearing pass. The result side cannot stall.
// ----------------------------------------------------------------------------
module fragment_frame_reassembler #(
  parameter int FRAG_BYTES = frr_pkg::FRAG_BYTES_DEF,
  parameter int MAX_FRAGS  = frr_pkg::MAX_FRAGS_DEF,
  parameter int SLOTS      = frr_pkg::SLOTS_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  frr_pkg::item_t   item,
  output logic             result_valid,
  output frr_pkg::result_t result
);

  localparam int SLOT_BYTES  = MAX_FRAGS * FRAG_BYTES;
  localparam int STORE_BYTES = SLOTS * SLOT_BYTES;
  localparam int SLOT_W      = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int POS_W       = $clog2(SLOT_BYTES);
  localparam int ADDR_W      = $clog2(STORE_BYTES);
  localparam int CNT_W       = frr_pkg::FRAG_CNT_W;
  localparam int FB_W        = frr_pkg::FRAME_BYTES_W;
  localparam int SF_W        = frr_pkg::SLOT_FIELD_W;
  localparam int BEF_W       = $clog2(FRAG_BYTES * (2 ** CNT_W));
  localparam int LIM_W       = (BEF_W > FB_W) ? BEF_W : FB_W;

  frr_pkg::state_t state, state_next;
  frr_pkg::item_t  item_q;

  // lookup results held for the update cycle
  frr_pkg::status_t  pend_status, pend_status_next;
  logic [SLOT_W-1:0] sel_slot;
  logic              sel_opening;
  logic [POS_W-1:0]  sel_pos, sel_pos_next;

  frr_pkg::lookup_t   lookup;
  logic [SLOT_W-1:0]  lookup_slot;
  logic               lookup_en;
  frr_pkg::slot_upd_t upd;
  frr_pkg::meta_t     upd_meta;
  frr_pkg::meta_t     rd_meta;

  logic              store_we;
  logic              store_re;
  logic [ADDR_W-1:0] store_addr;
  logic [7:0]        store_rdata;
  logic [SLOT_W-1:0] addr_slot;
  logic [POS_W-1:0]  addr_off;

  frr_pkg::result_t result_next;

  // header checks
  logic             hdr_ok;
  logic             last_frag;
  logic             rd_ok;
  logic             offs_ok;
  logic [LIM_W-1:0] prior_bytes;
  logic [LIM_W-1:0] fbytes_ext;
  logic [LIM_W-1:0] rem;
  logic [LIM_W-1:0] limit;

  // update arithmetic
  logic [CNT_W-1:0] seen_old;
  logic [CNT_W-1:0] seen_inc;
  logic [FB_W-1:0]  size_cur;
  logic             complete;

  frr_slot_table #(
    .SLOTS  (SLOTS),
    .SLOT_W (SLOT_W)
  ) u_slots (
    .clk         (clk),
    .rst         (rst),
    .lookup_id   (item_q.frame_number),
    .lookup_en   (lookup_en),
    .lookup      (lookup),
    .lookup_slot (lookup_slot),
    .upd         (upd),
    .upd_slot    (sel_slot),
    .upd_id      (item_q.frame_number),
    .upd_meta    (upd_meta),
    .rd_meta     (rd_meta)
  );

  frr_frame_store #(
    .DEPTH  (STORE_BYTES),
    .ADDR_W (ADDR_W)
  ) u_store (
    .clk   (clk),
    .we    (store_we),
    .re    (store_re),
    .addr  (store_addr),
    .wdata (item_q.payload_byte),
    .rdata (store_rdata)
  );

  always_comb begin
    hdr_ok = (item_q.frag_count != '0) && (int'(item_q.frag_count) <= MAX_FRAGS)
             && ({1'b0, item_q.frag_index} < item_q.frag_count);
    last_frag   = ({1'b0, item_q.frag_index} == (item_q.frag_count - CNT_W'(1)));
    prior_bytes = LIM_W'(FRAG_BYTES) * LIM_W'(item_q.frag_count - CNT_W'(1));
    fbytes_ext  = LIM_W'(item_q.frame_bytes);
    rem         = (fbytes_ext > prior_bytes) ? (fbytes_ext - prior_bytes) : '0;
    limit      = (last_frag && (rem < LIM_W'(FRAG_BYTES))) ? rem : LIM_W'(FRAG_BYTES);
    offs_ok    = LIM_W'(item_q.byte_offset) < limit;
    rd_ok      = (int'(item_q.read_slot) < SLOTS) && (int'(item_q.read_address) < SLOT_BYTES);
    sel_pos_next = POS_W'(item_q.frag_index) * POS_W'(FRAG_BYTES)
                   + POS_W'(item_q.byte_offset);

    priority if (item_q.mode) begin
      pend_status_next = rd_ok ? frr_pkg::ST_READ : frr_pkg::ST_RANGE;
    end else if (!hdr_ok || !offs_ok) begin
      pend_status_next = frr_pkg::ST_RANGE;
    end else if (!lookup.avail) begin
      pend_status_next = frr_pkg::ST_NO_SLOT;
    end else begin
      pend_status_next = frr_pkg::ST_STORED;
    end
  end

  // a freshly opened slot starts from zero, the memory entry is stale
  always_comb begin
    seen_old = sel_opening ? '0 : rd_meta.seen;
    size_cur = sel_opening ? item_q.frame_bytes : rd_meta.size;
    if (item_q.end_of_fragment && (seen_old != frr_pkg::SEEN_MAX)) begin
      seen_inc = seen_old + CNT_W'(1);
    end else begin
      seen_inc = seen_old;
    end
    complete = item_q.end_of_fragment && (seen_inc == item_q.frag_count);
  end

  // one address path shared by the read in lookup and the write in update
  always_comb begin
    addr_slot  = (state == frr_pkg::S_LOOKUP) ? SLOT_W'(item_q.read_slot) : sel_slot;
    addr_off   = (state == frr_pkg::S_LOOKUP) ? POS_W'(item_q.read_address) : sel_pos;
    store_addr = ADDR_W'(addr_slot) * ADDR_W'(SLOT_BYTES) + ADDR_W'(addr_off);
  end

  always_comb begin
    state_next = state;
    unique case (state)
      frr_pkg::S_IDLE:   if (start) state_next = frr_pkg::S_LOOKUP;
      frr_pkg::S_LOOKUP: state_next = frr_pkg::S_UPDATE;
      frr_pkg::S_UPDATE: state_next = frr_pkg::S_IDLE;
      default:           state_next = frr_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    busy          = (state != frr_pkg::S_IDLE);
    lookup_en     = 1'b0;
    store_re      = 1'b0;
    store_we      = 1'b0;
    upd           = '0;
    upd_meta.seen = complete ? '0 : seen_inc;
    upd_meta.size = size_cur;
    result_next   = '0;
    result_next.status = pend_status;
    unique case (state)
      frr_pkg::S_IDLE: begin
      end
      frr_pkg::S_LOOKUP: begin
        lookup_en = 1'b1;
        store_re  = item_q.mode && rd_ok;
      end
      frr_pkg::S_UPDATE: begin
        if (pend_status == frr_pkg::ST_STORED) begin
          store_we    = 1'b1;
          upd.open    = sel_opening;
          upd.close   = complete;
          upd.meta_we = sel_opening || item_q.end_of_fragment;
          if (complete) begin
            result_next.status            = frr_pkg::ST_DONE;
            result_next.done_frame_number = item_q.frame_number;
            result_next.done_slot         = SF_W'(sel_slot);
            result_next.done_frame_bytes  = size_cur;
          end
        end
        if (pend_status == frr_pkg::ST_READ) result_next.read_data = store_rdata;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= frr_pkg::S_IDLE;
      result_valid <= 1'b0;
    end else begin
      state        <= state_next;
      result_valid <= (state == frr_pkg::S_UPDATE);
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) item_q <= item;
    if (state == frr_pkg::S_LOOKUP) begin
      pend_status <= pend_status_next;
      sel_slot    <= lookup_slot;
      sel_opening <= !lookup.hit;
      sel_pos     <= sel_pos_next;
    end
    if (state == frr_pkg::S_UPDATE) result <= result_next;
  end

  a_result_after_update: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> $past(state == frr_pkg::S_UPDATE))
    else $error("result strobe without an update cycle");

  a_done_frees_slot: assert property (@(posedge clk) disable iff (rst)
    (result_valid && (result.status == frr_pkg::ST_DONE)) |-> $past(upd.close))
    else $error("frame reported complete but slot not freed");

  a_single_port: assert property (@(posedge clk) disable iff (rst)
    !(store_we && store_re))
    else $error("frame store read and write in one cycle");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted word did not raise busy");

endmodule

FILE: tb/fragment_frame_reassembler_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fragment_frame_reassembler_tb
// Self-checking bench: drives fragment bytes and reads through the start/busy
// command port, predicts every result word from its own slot table and byte
// store, and checks each strobed result against the oldest prediction.
// ----------------------------------------------------------------------------
module fragment_frame_reassembler_tb;

  localparam int FRAG_B     = frr_pkg::FRAG_BYTES_DEF;
  localparam int MAXF       = frr_pkg::MAX_FRAGS_DEF;
  localparam int NSLOT      = frr_pkg::SLOTS_DEF;
  localparam int SLOT_BYTES = frr_pkg::MAX_FRAGS_DEF * frr_pkg::FRAG_BYTES_DEF;
  localparam int JOBS       = 3;

  logic             clk;
  logic             rst;
  logic             start;
  logic             busy;
  frr_pkg::item_t   item;
  logic             result_valid;
  frr_pkg::result_t result;

  fragment_frame_reassembler u_top (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .item         (item),
    .result_valid (result_valid),
    .result       (result)
  );

  // predicted slot table and frame store
  logic                              slot_used [NSLOT];
  logic [frr_pkg::FRAME_ID_W-1:0]    slot_id   [NSLOT];
  logic [frr_pkg::FRAG_CNT_W-1:0]    slot_seen [NSLOT];
  logic [frr_pkg::FRAME_BYTES_W-1:0] slot_size [NSLOT];
  logic [7:0]                        frame_mem [int unsigned];
  int unsigned                       written_addrs [$];

  frr_pkg::result_t expected_words [$];
  int               mismatch_count;
  bit               no_gap_stretch;

  // frames in flight for the random traffic
  logic        job_live [JOBS];
  logic [31:0] job_id   [JOBS];
  int          job_cnt  [JOBS];
  int          job_size [JOBS];
  logic [63:0] job_done [JOBS];
  int          job_frag [JOBS];
  int          job_left [JOBS];

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("fragment_frame_reassembler_tb: FAIL");
    $finish;
  end

  // ---------------------------------------------------------------- predictor

  function automatic int frag_limit(int fidx, int fcnt, int fbytes);
    int prior_bytes;
    prior_bytes = FRAG_B * (fcnt - 1);
    if (fidx != fcnt - 1) return FRAG_B;
    if (fbytes <= prior_bytes) return 0;
    return (fbytes - prior_bytes < FRAG_B) ? fbytes - prior_bytes : FRAG_B;
  endfunction

  function automatic frr_pkg::result_t reassemble_word(frr_pkg::item_t w);
    frr_pkg::result_t r;
    int unsigned      addr;
    int               sl;
    r = '0;
    r.status = frr_pkg::ST_STORED;
    if (w.mode) begin
      if (int'(w.read_slot) >= NSLOT || int'(w.read_address) >= SLOT_BYTES) begin
        r.status = frr_pkg::ST_RANGE;
      end else begin
        r.status = frr_pkg::ST_READ;
        addr = int'(w.read_slot) * SLOT_BYTES + int'(w.read_address);
        if (frame_mem.exists(addr)) r.read_data = frame_mem[addr];
      end
      return r;
    end
    if (w.frag_count == 0 || int'(w.frag_count) > MAXF || w.frag_index >= w.frag_count) begin
      r.status = frr_pkg::ST_RANGE;
      return r;
    end
    if (int'(w.byte_offset) >= frag_limit(w.frag_index, w.frag_count, w.frame_bytes)) begin
      r.status = frr_pkg::ST_RANGE;
      return r;
    end
    sl = -1;
    for (int s = 0; s < NSLOT; s++)
      if (sl < 0 && slot_used[s] && slot_id[s] == w.frame_number) sl = s;
    for (int s = 0; s < NSLOT; s++)
      if (sl < 0 && !slot_used[s]) begin
        sl           = s;
        slot_used[s] = 1'b1;
        slot_id[s]   = w.frame_number;
        slot_seen[s] = '0;
        slot_size[s] = w.frame_bytes;
      end
    if (sl < 0) begin
      r.status = frr_pkg::ST_NO_SLOT;
      return r;
    end
    addr = sl * SLOT_BYTES + int'(w.frag_index) * FRAG_B + int'(w.byte_offset);
    frame_mem[addr] = w.payload_byte;
    written_addrs.push_back(addr);
    if (w.end_of_fragment) begin
      if (slot_seen[sl] < frr_pkg::SEEN_MAX) slot_seen[sl]++;
      if (slot_seen[sl] == w.frag_count) begin
        slot_used[sl]       = 1'b0;
        slot_seen[sl]       = '0;
        r.status            = frr_pkg::ST_DONE;
        r.done_frame_number = slot_id[sl];
        r.done_slot         = 3'(sl);
        r.done_frame_bytes  = slot_size[sl];
      end
    end
    return r;
  endfunction

  // ---------------------------------------------------------------- checking

  task automatic report_mismatch(input string field, input logic [31:0] got,
                                 input logic [31:0] want);
    mismatch_count++;
    if (mismatch_count <= 200)
      $display("%0t: mismatch on %s: got %0h, want %0h", $time, field, got, want);
  endtask

  task automatic compare_word(input frr_pkg::result_t got, input frr_pkg::result_t want);
    if (got.status !== want.status)
      report_mismatch("status", got.status, want.status);
    if (got.done_frame_number !== want.done_frame_number)
      report_mismatch("done_frame_number", got.done_frame_number, want.done_frame_number);
    if (got.done_slot !== want.done_slot)
      report_mismatch("done_slot", got.done_slot, want.done_slot);
    if (got.done_frame_bytes !== want.done_frame_bytes)
      report_mismatch("done_frame_bytes", got.done_frame_bytes, want.done_frame_bytes);
    if (got.read_data !== want.read_data)
      report_mismatch("read_data", got.read_data, want.read_data);
  endtask

  always @(posedge clk) begin
    if (!rst && result_valid) begin
      if (expected_words.size() == 0)
        report_mismatch("unexpected word", result.status, 0);
      else
        compare_word(result, expected_words.pop_front());
    end
  end

  // ---------------------------------------------------------------- driving

  function automatic int pick_gap();
    int r;
    if (no_gap_stretch) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // start is left high after acceptance so back-to-back words need no edge
  task automatic send_word(input frr_pkg::item_t w);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    item  <= w;
    @(posedge clk);
    while (busy) @(posedge clk);
    expected_words.push_back(reassemble_word(w));
  endtask

  function automatic frr_pkg::item_t frag_word(logic [31:0] id, int fidx, int fcnt,
                                               int fbytes, int offs, logic [7:0] data,
                                               bit eof);
    frr_pkg::item_t w;
    w.mode            = 1'b0;
    w.frame_number    = id;
    w.frag_index      = 6'(fidx);
    w.frag_count      = 7'(fcnt);
    w.frame_bytes     = 17'(fbytes);
    w.byte_offset     = 11'(offs);
    w.payload_byte    = data;
    w.end_of_fragment = eof;
    w.read_slot       = 3'($urandom());
    w.read_address    = 17'($urandom());
    return w;
  endfunction

  function automatic frr_pkg::item_t read_word(int sl, int addr);
    frr_pkg::item_t w;
    w              = frag_word($urandom(), $urandom(), $urandom(), $urandom(),
                               $urandom(), $urandom(), $urandom_range(0, 1));
    w.mode         = 1'b1;
    w.read_slot    = 3'(sl);
    w.read_address = 17'(addr);
    return w;
  endfunction

  function automatic int free_slot_count();
    int n;
    n = 0;
    for (int s = 0; s < NSLOT; s++) if (!slot_used[s]) n++;
    return n;
  endfunction

  function automatic int find_slot(logic [31:0] id);
    for (int s = 0; s < NSLOT; s++) if (slot_used[s] && slot_id[s] == id) return s;
    return 0;
  endfunction

  // completes the first open frame that no live job is building
  task automatic release_stale_slot();
    bit owned;
    int fcnt;
    for (int s = 0; s < NSLOT; s++) begin
      owned = 1'b0;
      for (int j = 0; j < JOBS; j++) if (job_live[j] && job_id[j] == slot_id[s]) owned = 1'b1;
      if (slot_used[s] && !owned && int'(slot_seen[s]) < MAXF) begin
        fcnt = int'(slot_seen[s]) + 1;
        send_word(frag_word(slot_id[s], 0, fcnt, FRAG_B * fcnt, 0, $urandom(), 1'b1));
        return;
      end
    end
  endtask

  task automatic read_back_written();
    int unsigned a;
    if (written_addrs.size() == 0) return;
    a = written_addrs[$urandom_range(0, written_addrs.size() - 1)];
    send_word(read_word(a / SLOT_BYTES, a % SLOT_BYTES));
  endtask

  // ---------------------------------------------------------------- tests

  task automatic test_field_extremes();
    logic [31:0] id;
    id = 32'hFFFF_FFFF;
    send_word(frag_word(id, 63, 64, 89600, 1399, 8'hFF, 1'b0));
    send_word(frag_word(id, 0, 64, 89600, 0, 8'h00, 1'b1));
    send_word(read_word(find_slot(id), SLOT_BYTES - 1));
    // header disagrees with the one that opened the slot: size stays 89600
    send_word(frag_word(id, 1, 2, 2800, 5, 8'h5A, 1'b1));
    send_word(frag_word(32'h0, 0, 1, 1, 0, 8'h81, 1'b1));
    send_word(frag_word(32'h1234_5678, 0, 1, 131071, 1399, 8'h7E, 1'b1));
  endtask

  task automatic test_bad_headers();
    send_word(frag_word(32'h0000_00B0, 0, 0, 100, 0, 8'h11, 1'b1));
    send_word(frag_word(32'h0000_00B0, 0, 65, 100, 0, 8'h22, 1'b1));
    send_word(frag_word(32'h0000_00B0, 0, 127, 100, 0, 8'h33, 1'b1));
    send_word(frag_word(32'h0000_00B0, 5, 5, 7000, 0, 8'h44, 1'b1));
    send_word(frag_word(32'h0000_00B0, 63, 10, 14000, 0, 8'h55, 1'b1));
  endtask

  task automatic test_fragment_cut();
    logic [31:0] id;
    id = 32'h0000_C0C0;
    send_word(frag_word(id, 0, 2, 1500, 1400, 8'h01, 1'b0));
    send_word(frag_word(id, 0, 2, 1500, 2047, 8'h02, 1'b1));
    // last fragment holds 100 bytes; offset 100 is dropped, eof with it
    send_word(frag_word(id, 1, 2, 1500, 100, 8'h03, 1'b1));
    send_word(frag_word(id, 1, 2, 1500, 99, 8'h04, 1'b1));
    send_word(frag_word(id, 0, 2, 1500, 0, 8'h05, 1'b1));
    send_word(frag_word(id + 1, 2, 3, 2000, 0, 8'h06, 1'b1));
    send_word(frag_word(id + 1, 0, 1, 0, 0, 8'h07, 1'b1));
  endtask

  task automatic test_duplicate_fragments();
    logic [31:0] id;
    id = 32'h0D0D_0D0D;
    send_word(frag_word(id, 0, 2, 2000, 3, 8'hA1, 1'b1));
    send_word(frag_word(id, 0, 2, 2000, 3, 8'hA2, 1'b1));
    send_word(frag_word(id, 1, 2, 2000, 7, 8'hA3, 1'b1));
    send_word(frag_word(id, 1, 2, 2000, 7, 8'hA4, 1'b1));
  endtask

  task automatic test_no_free_slot();
    int n;
    n = 0;
    while (free_slot_count() > 0) begin
      send_word(frag_word(32'h5100_0000 + n, 0, 1, 10, n % 10, $urandom(), 1'b0));
      n++;
    end
    send_word(frag_word(32'h5100_00FF, 0, 1, 10, 0, 8'hEE, 1'b1));
    while (free_slot_count() < NSLOT) release_stale_slot();
  endtask

  task automatic test_reads();
    send_word(read_word(0, SLOT_BYTES));
    send_word(read_word(NSLOT - 1, 131071));
    repeat (4) read_back_written();
  endtask

  task automatic send_job_byte(input int j, input bit broken);
    int fi, lim, offs, k;
    if (!job_live[j]) begin
      job_live[j] = 1'b1;
      job_id[j]   = $urandom();
      job_cnt[j]  = ($urandom_range(0, 99) < 85) ? $urandom_range(1, 4) : $urandom_range(5, MAXF);
      job_size[j] = $urandom_range(FRAG_B * (job_cnt[j] - 1) + 1, FRAG_B * job_cnt[j]);
      job_done[j] = '0;
      job_left[j] = 0;
    end
    if (job_left[j] == 0) begin
      fi = $urandom_range(0, job_cnt[j] - 1);
      // now and then resend a finished fragment
      if ($urandom_range(0, 99) >= 5)
        for (k = 0; k < job_cnt[j]; k++) if (job_done[j][fi]) fi = (fi + 1) % job_cnt[j];
      job_frag[j] = fi;
      job_left[j] = $urandom_range(1, 3);
    end
    lim = frag_limit(job_frag[j], job_cnt[j], job_size[j]);
    if (broken) begin
      offs = lim + $urandom_range(0, 40);
      send_word(frag_word(job_id[j], job_frag[j], job_cnt[j], job_size[j], offs, $urandom(),
                          $urandom_range(0, 1)));
      return;
    end
    offs = $urandom_range(0, lim - 1);
    send_word(frag_word(job_id[j], job_frag[j], job_cnt[j], job_size[j], offs, $urandom(),
                        job_left[j] == 1));
    job_left[j]--;
    if (job_left[j] == 0) begin
      job_done[j][job_frag[j]] = 1'b1;
      if (job_done[j] == (64'd1 << job_cnt[j]) - 64'd1) job_live[j] = 1'b0;
    end
  endtask

  task automatic test_random_traffic(input int words);
    frr_pkg::item_t w;
    int             r, sent;
    for (int j = 0; j < JOBS; j++) job_live[j] = 1'b0;
    sent = 0;
    while (sent < words) begin
      if (sent % 150 == 0) no_gap_stretch = ($urandom_range(0, 2) == 0);
      if (free_slot_count() < 2) release_stale_slot();
      r = $urandom_range(0, 99);
      if (r < 65) begin
        send_job_byte($urandom_range(0, JOBS - 1), 1'b0);
      end else if (r < 80) begin
        if ($urandom_range(0, 4) != 0)
          read_back_written();
        else
          send_word(read_word($urandom_range(0, NSLOT - 1), $urandom_range(SLOT_BYTES, 131071)));
      end else if (r < 90) begin
        w = frag_word($urandom(), $urandom(), $urandom(), $urandom(), $urandom(), $urandom(),
                      $urandom_range(0, 1));
        send_word(w);
      end else begin
        send_job_byte($urandom_range(0, JOBS - 1), 1'b1);
      end
      sent++;
    end
    no_gap_stretch = 1'b0;
    for (int j = 0; j < JOBS; j++) job_live[j] = 1'b0;
  endtask

  // drives one frame's count past 127; a wrapping counter would reach 2 and close it
  task automatic test_counter_saturation();
    logic [31:0] id;
    int          k;
    id = 32'hA5A5_0001;
    if (free_slot_count() == 0) release_stale_slot();
    for (k = 0; k < 63; k++) send_word(frag_word(id, k, 64, 89600, 0, $urandom(), 1'b1));
    for (k = 0; k < 150; k++) send_word(frag_word(id, 0, 2, 2800, 0, $urandom(), 1'b1));
  endtask

  // ---------------------------------------------------------------- sequence

  initial begin
    rst            = 1'b1;
    start          = 1'b0;
    item           = '0;
    mismatch_count = 0;
    no_gap_stretch = 1'b0;
    for (int s = 0; s < NSLOT; s++) begin
      slot_used[s] = 1'b0;
      slot_id[s]   = '0;
      slot_seen[s] = '0;
      slot_size[s] = '0;
    end
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_field_extremes();
    test_bad_headers();
    test_fragment_cut();
    test_duplicate_fragments();
    test_no_free_slot();
    test_reads();
    test_random_traffic(850);
    test_counter_saturation();

    start <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatch_count == 0)
      $display("fragment_frame_reassembler_tb: PASS");
    else
      $display("fragment_frame_reassembler_tb: FAIL");
    $finish;
  end

endmodule
